// ===== src/source_continuation_scanner_core_macros.svh =====
// Assertion helpers used by the bind checker of the scanner.
`ifndef SOURCE_CONTINUATION_SCANNER_CORE_MACROS_SVH
`define SOURCE_CONTINUATION_SCANNER_CORE_MACROS_SVH

// Checked on every edge outside reset.
`define SCS_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define SCS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/scs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package scs_pkg;

  localparam int LEVEL_MAX_DEFAULT = 255;

  // Characters that steer the scan.
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_STAR      = 8'h2A;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_BACKTICK  = 8'h60;
  localparam logic [7:0] CH_DQUOTE    = 8'h22;
  localparam logic [7:0] CH_SQUOTE    = 8'h27;
  localparam logic [7:0] CH_LPAREN    = 8'h28;
  localparam logic [7:0] CH_RPAREN    = 8'h29;
  localparam logic [7:0] CH_LSQUARE   = 8'h5B;
  localparam logic [7:0] CH_RSQUARE   = 8'h5D;
  localparam logic [7:0] CH_LCURLY    = 8'h7B;
  localparam logic [7:0] CH_RCURLY    = 8'h7D;

  // Context codes as they appear on the result port.
  localparam logic [2:0] CODE_CODE  = 3'd0;
  localparam logic [2:0] CODE_LINE  = 3'd1;
  localparam logic [2:0] CODE_BLOCK = 3'd2;
  localparam logic [2:0] CODE_SQ    = 3'd3;
  localparam logic [2:0] CODE_DQ    = 3'd4;
  localparam logic [2:0] CODE_BT    = 3'd5;

  typedef enum logic [5:0] {
    CTX_CODE  = 6'b000001,
    CTX_LINE  = 6'b000010,
    CTX_BLOCK = 6'b000100,
    CTX_SQ    = 6'b001000,
    CTX_DQ    = 6'b010000,
    CTX_BT    = 6'b100000
  } ctx_t;

  typedef struct packed {
    ctx_t       ctx;
    logic       escape;
    logic       slash;
    logic       star;
    logic [7:0] paren;
    logic [7:0] square;
    logic [7:0] curly;
    logic       sat;
  } scan_state_t;

  typedef struct packed {
    logic       needs_more;
    logic [7:0] paren_level;
    logic [7:0] square_level;
    logic [7:0] curly_level;
    logic [2:0] lex_context;
    logic       level_saturated;
  } scan_result_t;

  localparam scan_state_t SCAN_STATE_RESET = '{
    ctx: CTX_CODE, escape: 1'b0, slash: 1'b0, star: 1'b0,
    paren: 8'd0, square: 8'd0, curly: 8'd0, sat: 1'b0
  };

  function automatic logic [2:0] ctx_code(input ctx_t ctx);
    logic [2:0] code;
    case (ctx)
      CTX_LINE:  code = CODE_LINE;
      CTX_BLOCK: code = CODE_BLOCK;
      CTX_SQ:    code = CODE_SQ;
      CTX_DQ:    code = CODE_DQ;
      CTX_BT:    code = CODE_BT;
      default:   code = CODE_CODE;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

// ===== src/scs_step.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Next scan state and the result for one byte.
module scs_step
  import scs_pkg::*;
#(
  parameter logic [7:0] LEVEL_LIMIT = 8'd255
) (
  input  scan_state_t  cur,
  input  logic [7:0]   text_byte,
  input  logic         end_of_buffer,
  output scan_state_t  nxt,
  output scan_result_t res
);

  scan_state_t upd;
  logic [7:0]  closer;
  logic        slash_taken;

  always_comb begin
    upd = cur;
    slash_taken = 1'b0;
    case (cur.ctx)
      CTX_SQ:  closer = CH_SQUOTE;
      CTX_DQ:  closer = CH_DQUOTE;
      default: closer = CH_BACKTICK;
    endcase

    case (cur.ctx)
      CTX_LINE: begin
        if (text_byte == CH_NEWLINE) upd.ctx = CTX_CODE;
      end
      CTX_BLOCK: begin
        if (cur.star && text_byte == CH_SLASH) begin
          upd.ctx = CTX_CODE;
          upd.star = 1'b0;
        end else begin
          upd.star = (text_byte == CH_STAR);
        end
      end
      CTX_SQ, CTX_DQ, CTX_BT: begin
        if (cur.escape) begin
          upd.escape = 1'b0;
        end else if (text_byte == CH_BACKSLASH) begin
          upd.escape = 1'b1;
        end else if (text_byte == closer) begin
          upd.ctx = CTX_CODE;
        end
      end
      default: begin
        upd.ctx = CTX_CODE;
        // A pending slash decides whether this byte opens a comment.
        if (cur.slash) begin
          upd.slash = 1'b0;
          if (text_byte == CH_SLASH) begin
            upd.ctx = CTX_LINE;
            slash_taken = 1'b1;
          end else if (text_byte == CH_STAR) begin
            upd.ctx = CTX_BLOCK;
            upd.star = 1'b0;
            slash_taken = 1'b1;
          end
        end
        if (!slash_taken) begin
          case (text_byte)
            CH_SLASH: upd.slash = 1'b1;
            CH_SQUOTE: begin
              upd.ctx = CTX_SQ;
              upd.escape = 1'b0;
            end
            CH_DQUOTE: begin
              upd.ctx = CTX_DQ;
              upd.escape = 1'b0;
            end
            CH_BACKTICK: begin
              upd.ctx = CTX_BT;
              upd.escape = 1'b0;
            end
            CH_LPAREN: begin
              if (cur.paren >= LEVEL_LIMIT) upd.sat = 1'b1;
              else upd.paren = cur.paren + 8'd1;
            end
            CH_RPAREN: begin
              if (cur.paren != 8'd0) upd.paren = cur.paren - 8'd1;
            end
            CH_LSQUARE: begin
              if (cur.square >= LEVEL_LIMIT) upd.sat = 1'b1;
              else upd.square = cur.square + 8'd1;
            end
            CH_RSQUARE: begin
              if (cur.square != 8'd0) upd.square = cur.square - 8'd1;
            end
            CH_LCURLY: begin
              if (cur.curly >= LEVEL_LIMIT) upd.sat = 1'b1;
              else upd.curly = cur.curly + 8'd1;
            end
            CH_RCURLY: begin
              if (cur.curly != 8'd0) upd.curly = cur.curly - 8'd1;
            end
            default: ;
          endcase
        end
      end
    endcase

    res.needs_more = (upd.paren != 8'd0) || (upd.square != 8'd0) || (upd.curly != 8'd0) ||
                     (upd.ctx != CTX_CODE && upd.ctx != CTX_LINE);
    res.paren_level = upd.paren;
    res.square_level = upd.square;
    res.curly_level = upd.curly;
    res.lex_context = ctx_code(upd.ctx);
    res.level_saturated = upd.sat;

    nxt = end_of_buffer ? SCAN_STATE_RESET : upd;
  end

endmodule

`default_nettype wire

// ===== src/source_continuation_scanner_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Streaming bracket and continuation scanner for script text.
// Input channel: one byte per beat (text_byte, end_of_buffer) on in_valid/in_stall.
// Output channel: one result beat per input beat on out_valid/out_stall, carrying
// needs_more, the three bracket levels, the lexical context code and the sticky
// saturation flag, all as they stand after that byte.
// A byte's result is registered: into the result register, or into the skid register while a result is stalled.
// Throughput is one byte per cycle while in_stall is low; the scan state update and the counter step
// for a byte are combinational logic between the state and result registers.
// A two-entry output buffer (result register plus skid register) lets one more
// byte be taken while a result is stalled; in_stall rises only when both hold
// results, and it comes from a register.
// A byte with end_of_buffer set reports its own result and then returns the scan
// state to plain code with all levels at zero.
// Reset (rst, synchronous) clears the scan state and drops both output entries.
module source_continuation_scanner_core
  import scs_pkg::*;
#(
  parameter int LEVEL_MAX = LEVEL_MAX_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] text_byte,
  input  logic       end_of_buffer,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       needs_more,
  output logic [7:0] paren_level,
  output logic [7:0] square_level,
  output logic [7:0] curly_level,
  output logic [2:0] lex_context,
  output logic       level_saturated
);

  localparam logic [7:0] LEVEL_LIMIT = (LEVEL_MAX > 255) ? 8'd255 : 8'(LEVEL_MAX);

  scan_state_t  state;
  scan_state_t  state_next;
  scan_result_t step_res;
  scan_result_t out_res;
  scan_result_t skid_res;
  logic         skid_valid;
  logic         accept;

  scs_step #(.LEVEL_LIMIT(LEVEL_LIMIT)) u_step (
    .cur           (state),
    .text_byte     (text_byte),
    .end_of_buffer (end_of_buffer),
    .nxt           (state_next),
    .res           (step_res)
  );

  assign in_stall = skid_valid;
  assign accept = in_valid && !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SCAN_STATE_RESET;
    end else if (accept) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (accept) begin
      if (out_valid && out_stall) begin
        skid_valid <= 1'b1;
        skid_res <= step_res;
      end else begin
        out_valid <= 1'b1;
        out_res <= step_res;
      end
    end else if (out_valid && !out_stall) begin
      // Refill the result register from the skid entry once its beat is taken.
      if (skid_valid) begin
        out_res <= skid_res;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  assign needs_more = out_res.needs_more;
  assign paren_level = out_res.paren_level;
  assign square_level = out_res.square_level;
  assign curly_level = out_res.curly_level;
  assign lex_context = out_res.lex_context;
  assign level_saturated = out_res.level_saturated;

endmodule

`default_nettype wire

// ===== src/scs_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "source_continuation_scanner_core_macros.svh"

module scs_checker
  import scs_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] text_byte,
  input logic       end_of_buffer,
  input logic       out_valid,
  input logic       out_stall,
  input logic       needs_more,
  input logic [7:0] paren_level,
  input logic [7:0] square_level,
  input logic [7:0] curly_level,
  input logic [2:0] lex_context,
  input logic       level_saturated
);

  logic        open_any;
  logic        in_beat;
  logic        in_held;
  logic        out_held;
  logic [8:0]  in_word;
  logic [28:0] out_word;

  assign open_any = (paren_level != 8'd0) || (square_level != 8'd0) ||
                    (curly_level != 8'd0) ||
                    (lex_context inside {CODE_BLOCK, CODE_SQ, CODE_DQ, CODE_BT});
  assign in_beat = in_valid && !in_stall;
  assign in_held = in_valid && in_stall;
  assign out_held = out_valid && out_stall;
  assign in_word = {text_byte, end_of_buffer};
  assign out_word = {needs_more, paren_level, square_level, curly_level, lex_context,
                     level_saturated};

  `SCS_ASSERT_ALWAYS(a_reset_empties, clk, rst |=> !out_valid, "result left after reset")
  `SCS_ASSERT(a_more_matches, clk, rst, out_valid |-> (needs_more == open_any), "bad needs_more")
  `SCS_ASSERT(a_out_holds, clk, rst, out_held |=> out_valid && $stable(out_word), "result changed")
  `SCS_ASSERT(a_in_holds, clk, rst, in_held |=> in_valid && $stable(in_word), "byte changed")
  `SCS_ASSERT(a_beat_gives_result, clk, rst, in_beat |=> out_valid, "byte gave no result")

endmodule

bind source_continuation_scanner_core scs_checker u_scs_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .text_byte       (text_byte),
  .end_of_buffer   (end_of_buffer),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .needs_more      (needs_more),
  .paren_level     (paren_level),
  .square_level    (square_level),
  .curly_level     (curly_level),
  .lex_context     (lex_context),
  .level_saturated (level_saturated)
);

`default_nettype wire

// ===== verif/source_continuation_scanner_core_checker.sv =====
`timescale 1ns / 1ps

module source_continuation_scanner_core_checker
  import scs_pkg::*;
#(
  parameter int LEVEL_MAX = LEVEL_MAX_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] text_byte,
  input  logic       end_of_buffer,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic       needs_more,
  input  logic [7:0] paren_level,
  input  logic [7:0] square_level,
  input  logic [7:0] curly_level,
  input  logic [2:0] lex_context,
  input  logic       level_saturated,
  output int         fail_count,
  output int         outstanding
);

  localparam logic [7:0] LEVEL_LIMIT = (LEVEL_MAX > 255) ? 8'd255 : 8'(LEVEL_MAX);

  // Scan state as the block should hold it.
  logic [2:0] ctx_q;
  logic       escape_q;
  logic       slash_q;
  logic       star_q;
  logic [7:0] paren_q;
  logic [7:0] square_q;
  logic [7:0] curly_q;
  logic       sat_q;

  scan_result_t expected_results[$];

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  task automatic clear_scan();
    ctx_q    = CODE_CODE;
    escape_q = 1'b0;
    slash_q  = 1'b0;
    star_q   = 1'b0;
    paren_q  = 8'd0;
    square_q = 8'd0;
    curly_q  = 8'd0;
    sat_q    = 1'b0;
  endtask

  task automatic scan_next_byte(input logic [7:0] b, input logic last,
                                output scan_result_t res);
    logic       taken;
    logic [7:0] closer;
    taken = 1'b0;
    closer = CH_BACKTICK;
    case (ctx_q)
      CODE_LINE: begin
        if (b == CH_NEWLINE) ctx_q = CODE_CODE;
      end
      CODE_BLOCK: begin
        if (star_q && b == CH_SLASH) begin
          ctx_q  = CODE_CODE;
          star_q = 1'b0;
        end else begin
          star_q = (b == CH_STAR);
        end
      end
      CODE_SQ, CODE_DQ, CODE_BT: begin
        if (ctx_q == CODE_SQ) closer = CH_SQUOTE;
        else if (ctx_q == CODE_DQ) closer = CH_DQUOTE;
        if (escape_q) escape_q = 1'b0;
        else if (b == CH_BACKSLASH) escape_q = 1'b1;
        else if (b == closer) ctx_q = CODE_CODE;
      end
      default: begin
        ctx_q = CODE_CODE;
        // A slash from the previous byte decides whether a comment opens.
        if (slash_q) begin
          slash_q = 1'b0;
          if (b == CH_SLASH) begin
            ctx_q = CODE_LINE;
            taken = 1'b1;
          end else if (b == CH_STAR) begin
            ctx_q  = CODE_BLOCK;
            star_q = 1'b0;
            taken  = 1'b1;
          end
        end
        if (!taken) begin
          case (b)
            CH_SLASH:  slash_q = 1'b1;
            CH_SQUOTE: begin ctx_q = CODE_SQ; escape_q = 1'b0; end
            CH_DQUOTE: begin ctx_q = CODE_DQ; escape_q = 1'b0; end
            CH_BACKTICK: begin ctx_q = CODE_BT; escape_q = 1'b0; end
            CH_LPAREN: begin
              if (paren_q >= LEVEL_LIMIT) sat_q = 1'b1;
              else paren_q = paren_q + 8'd1;
            end
            CH_LSQUARE: begin
              if (square_q >= LEVEL_LIMIT) sat_q = 1'b1;
              else square_q = square_q + 8'd1;
            end
            CH_LCURLY: begin
              if (curly_q >= LEVEL_LIMIT) sat_q = 1'b1;
              else curly_q = curly_q + 8'd1;
            end
            CH_RPAREN:  if (paren_q != 8'd0) paren_q = paren_q - 8'd1;
            CH_RSQUARE: if (square_q != 8'd0) square_q = square_q - 8'd1;
            CH_RCURLY:  if (curly_q != 8'd0) curly_q = curly_q - 8'd1;
            default: ;
          endcase
        end
      end
    endcase

    res.needs_more = (paren_q != 8'd0) || (square_q != 8'd0) || (curly_q != 8'd0) ||
                     (ctx_q == CODE_BLOCK) || (ctx_q == CODE_SQ) ||
                     (ctx_q == CODE_DQ) || (ctx_q == CODE_BT);
    res.paren_level     = paren_q;
    res.square_level    = square_q;
    res.curly_level     = curly_q;
    res.lex_context     = ctx_q;
    res.level_saturated = sat_q;

    if (last) clear_scan();
  endtask

  always @(posedge clk) begin
    scan_result_t want;
    if (rst) begin
      clear_scan();
      expected_results.delete();
    end else begin
      // A result leaves only after its byte has been registered, so retire before adding.
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result beat with no byte waiting", 1, 0);
        end else begin
          want = expected_results.pop_front();
          if (needs_more !== want.needs_more)
            report_mismatch("needs_more", int'(needs_more), int'(want.needs_more));
          if (paren_level !== want.paren_level)
            report_mismatch("paren_level", int'(paren_level), int'(want.paren_level));
          if (square_level !== want.square_level)
            report_mismatch("square_level", int'(square_level), int'(want.square_level));
          if (curly_level !== want.curly_level)
            report_mismatch("curly_level", int'(curly_level), int'(want.curly_level));
          if (lex_context !== want.lex_context)
            report_mismatch("lex_context", int'(lex_context), int'(want.lex_context));
          if (level_saturated !== want.level_saturated)
            report_mismatch("level_saturated", int'(level_saturated),
                            int'(want.level_saturated));
        end
      end
      if (in_valid && !in_stall) begin
        scan_next_byte(text_byte, end_of_buffer, want);
        expected_results.push_back(want);
      end
    end
    outstanding <= expected_results.size();
  end

endmodule

// ===== verif/source_continuation_scanner_core_tb.sv =====
`timescale 1ns / 1ps

module source_continuation_scanner_core_tb;
  import scs_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_BYTES = 1000;
  localparam logic [7:0] CH_SPACE = 8'h20;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] text_byte = 8'd0;
  logic       end_of_buffer = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       needs_more;
  logic [7:0] paren_level;
  logic [7:0] square_level;
  logic [7:0] curly_level;
  logic [2:0] lex_context;
  logic       level_saturated;

  int fail_count;
  int outstanding;
  int cycle_count = 0;
  bit no_idle = 1'b0;

  logic [7:0] script_bytes[$];

  source_continuation_scanner_core u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .text_byte      (text_byte),
    .end_of_buffer  (end_of_buffer),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .needs_more     (needs_more),
    .paren_level    (paren_level),
    .square_level   (square_level),
    .curly_level    (curly_level),
    .lex_context    (lex_context),
    .level_saturated(level_saturated)
  );

  source_continuation_scanner_core_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .text_byte      (text_byte),
    .end_of_buffer  (end_of_buffer),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .needs_more     (needs_more),
    .paren_level    (paren_level),
    .square_level   (square_level),
    .curly_level    (curly_level),
    .lex_context    (lex_context),
    .level_saturated(level_saturated),
    .fail_count     (fail_count),
    .outstanding    (outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result side: a random hold before each beat, none while no_idle is set.
  initial begin
    int hold;
    @(posedge clk);
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, 3);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  function automatic logic [7:0] pick_special();
    logic [7:0] c;
    case ($urandom_range(0, 13))
      0:  c = CH_NEWLINE;
      1:  c = CH_STAR;
      2:  c = CH_SLASH;
      3:  c = CH_BACKSLASH;
      4:  c = CH_BACKTICK;
      5:  c = CH_DQUOTE;
      6:  c = CH_SQUOTE;
      7:  c = CH_LPAREN;
      8:  c = CH_RPAREN;
      9:  c = CH_LSQUARE;
      10: c = CH_RSQUARE;
      11: c = CH_LCURLY;
      12: c = CH_RCURLY;
      default: c = 8'($urandom_range(0, 255));
    endcase
    return c;
  endfunction

  function automatic logic [7:0] pick_text();
    logic [7:0] c;
    case ($urandom_range(0, 5))
      0, 1: c = pick_special();
      2:    c = CH_SPACE;
      default: c = 8'($urandom_range(8'h61, 8'h7A));
    endcase
    return c;
  endfunction

  function automatic logic [7:0] pick_quote();
    logic [7:0] q;
    case ($urandom_range(0, 2))
      0: q = CH_SQUOTE;
      1: q = CH_DQUOTE;
      default: q = CH_BACKTICK;
    endcase
    return q;
  endfunction

  // Appends one lexical piece of script; most are well formed, a few are cut short.
  task automatic add_token();
    int kind, n, i;
    logic [7:0] quote;
    kind = $urandom_range(0, 10);
    case (kind)
      0, 1: begin
        n = $urandom_range(1, 4);
        for (i = 0; i < n; i++) script_bytes.push_back(8'($urandom_range(8'h61, 8'h7A)));
      end
      2: begin
        case ($urandom_range(0, 2))
          0: script_bytes.push_back(CH_LPAREN);
          1: script_bytes.push_back(CH_LSQUARE);
          default: script_bytes.push_back(CH_LCURLY);
        endcase
      end
      3: begin
        case ($urandom_range(0, 2))
          0: script_bytes.push_back(CH_RPAREN);
          1: script_bytes.push_back(CH_RSQUARE);
          default: script_bytes.push_back(CH_RCURLY);
        endcase
      end
      4: begin
        quote = pick_quote();
        script_bytes.push_back(quote);
        n = $urandom_range(0, 5);
        for (i = 0; i < n; i++) begin
          if ($urandom_range(0, 3) == 0) begin
            script_bytes.push_back(CH_BACKSLASH);
            script_bytes.push_back($urandom_range(0, 1) ? quote : pick_text());
          end else begin
            script_bytes.push_back(pick_text());
          end
        end
        if ($urandom_range(0, 7) != 0) script_bytes.push_back(quote);
      end
      5: begin
        script_bytes.push_back(CH_SLASH);
        script_bytes.push_back(CH_SLASH);
        n = $urandom_range(0, 4);
        for (i = 0; i < n; i++) script_bytes.push_back(pick_text());
        if ($urandom_range(0, 5) != 0) script_bytes.push_back(CH_NEWLINE);
      end
      6: begin
        script_bytes.push_back(CH_SLASH);
        script_bytes.push_back(CH_STAR);
        n = $urandom_range(0, 5);
        for (i = 0; i < n; i++) begin
          case ($urandom_range(0, 3))
            0: script_bytes.push_back(CH_STAR);
            1: script_bytes.push_back(CH_SLASH);
            default: script_bytes.push_back(pick_text());
          endcase
        end
        if ($urandom_range(0, 7) != 0) begin
          script_bytes.push_back(CH_STAR);
          script_bytes.push_back(CH_SLASH);
        end
      end
      7: begin
        script_bytes.push_back(CH_SLASH);
        script_bytes.push_back(pick_text());
      end
      8: script_bytes.push_back(8'($urandom_range(0, 255)));
      9: script_bytes.push_back($urandom_range(0, 1) ? CH_NEWLINE : CH_SPACE);
      default: script_bytes.push_back(pick_special());
    endcase
  endtask

  task automatic send_beat(input logic [7:0] b, input logic last);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    text_byte     <= b;
    end_of_buffer <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Sends the queued script; the final byte, and the one at cut if any, close a buffer.
  task automatic send_script(input int cut);
    int i;
    for (i = 0; i < script_bytes.size(); i++)
      send_beat(script_bytes[i], (i == script_bytes.size() - 1) || (i == cut));
    script_bytes.delete();
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    int random_sent, buffer_idx, n, cut, i;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Field extremes, closers at depth zero, then every opener.
    script_bytes = '{8'h00, 8'hFF, CH_RPAREN, CH_RSQUARE, CH_RCURLY,
                     CH_LPAREN, CH_LSQUARE, CH_LCURLY,
                     // A lone slash falls through to ordinary code.
                     CH_SLASH, CH_LPAREN,
                     // Escaped quote inside a double-quoted string.
                     CH_DQUOTE, CH_BACKSLASH, CH_DQUOTE, CH_DQUOTE,
                     CH_SQUOTE, CH_BACKTICK, CH_SQUOTE,
                     // The star that opens a block comment cannot also close it.
                     CH_SLASH, CH_STAR, CH_SLASH, CH_STAR, CH_SLASH,
                     CH_SLASH, CH_SLASH, CH_LPAREN, CH_NEWLINE,
                     CH_BACKTICK};
    send_script(-1);
    // A buffer that ends on a pending slash.
    script_bytes.push_back(CH_SLASH);
    send_script(-1);
    wait_drained();

    // Drive every counter into its limit, then back off a little.
    no_idle = 1'b1;
    for (i = 0; i < 258; i++) begin
      script_bytes.push_back(CH_LPAREN);
      script_bytes.push_back(CH_LSQUARE);
      script_bytes.push_back(CH_LCURLY);
    end
    script_bytes.push_back(CH_RCURLY);
    script_bytes.push_back(CH_LCURLY);
    script_bytes.push_back(CH_LCURLY);
    script_bytes.push_back(CH_RPAREN);
    send_script(-1);
    no_idle = 1'b0;

    random_sent = 0;
    buffer_idx  = 0;
    while (random_sent < RANDOM_BYTES) begin
      n = $urandom_range(1, 12);
      repeat (n) add_token();
      cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, script_bytes.size() - 1) : -1;
      random_sent += script_bytes.size();
      send_script(cut);
      buffer_idx++;
      if (buffer_idx % 8 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if (buffer_idx % 20 == 0) wait_drained();
    end

    no_idle = 1'b0;
    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== source_continuation_scanner_core.f =====
+incdir+src
src/scs_pkg.sv
src/scs_step.sv
src/source_continuation_scanner_core.sv
src/scs_checker.sv
verif/source_continuation_scanner_core_checker.sv
verif/source_continuation_scanner_core_tb.sv
